### sv/morb_pkg.sv
// Package for the Morton BIGMIN block: work item type, bit-triple codes and step function
package morb_pkg;

	localparam int KEY_W = 64;

	localparam logic [KEY_W-1:0] LANE_2D = 64'h5555_5555_5555_5555;
	localparam logic [KEY_W-1:0] LANE_8D = 64'h0101_0101_0101_0101;

	// bit triple {current, min, max}
	localparam logic [2:0] CODE_LOAD_BOTH = 3'b001;
	localparam logic [2:0] CODE_BAD_LO    = 3'b010;
	localparam logic [2:0] CODE_TAKE_MIN  = 3'b011;
	localparam logic [2:0] CODE_TAKE_BEST = 3'b100;
	localparam logic [2:0] CODE_LOAD_MIN  = 3'b101;
	localparam logic [2:0] CODE_BAD_HI    = 3'b110;

	typedef struct packed {
		logic [KEY_W-1:0] cur;
		logic [KEY_W-1:0] zmin;
		logic [KEY_W-1:0] zmax;
		logic [KEY_W-1:0] best;
		logic             invalid;
		logic             done;
		logic             eight;
	} morb_work_t;

	// one bit position of the scan
	function automatic morb_work_t morb_step(morb_work_t w, logic [5:0] pos);
		logic [KEY_W-1:0] upto;
		logic [KEY_W-1:0] lane;
		logic [KEY_W-1:0] bitp;
		logic [2:0]       code;
		morb_work_t       r;
		r    = w;
		upto = (pos == 6'd63) ? '1 : ((64'd1 << ({1'b0, pos} + 7'd1)) - 64'd1);
		lane = (w.eight ? (LANE_8D << pos[2:0]) : (LANE_2D << pos[0])) & upto;
		bitp = 64'd1 << pos;
		code = {w.cur[pos], w.zmin[pos], w.zmax[pos]};
		if (!w.done) begin
			case (code) inside
				CODE_LOAD_BOTH: begin
					r.best = (w.zmin & ~lane) | bitp;
					r.zmax = (w.zmax & ~lane) | (lane & ~bitp);
				end
				CODE_BAD_LO, CODE_BAD_HI: begin
					r.best    = '1;
					r.invalid = 1'b1;
					r.done    = 1'b1;
				end
				CODE_TAKE_MIN: begin
					r.best = w.zmin;
					r.done = 1'b1;
				end
				CODE_TAKE_BEST: begin
					r.done = 1'b1;
				end
				CODE_LOAD_MIN: begin
					r.zmin = (w.zmin & ~lane) | bitp;
				end
				default: begin
				end
			endcase
		end
		return r;
	endfunction

endpackage

### sv/morb_if.sv
// Valid/ready channel interfaces for the request and result items
interface morb_req_if;
	import morb_pkg::*;
	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] current_key;
	logic [KEY_W-1:0] box_min_key;
	logic [KEY_W-1:0] box_max_key;
	modport source (output valid, output current_key, output box_min_key,
		output box_max_key, input ready);
	modport sink (input valid, input current_key, input box_min_key,
		input box_max_key, output ready);
endinterface

interface morb_rsp_if;
	import morb_pkg::*;
	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] next_key;
	logic             box_invalid;
	modport source (output valid, output next_key, output box_invalid, input ready);
	modport sink (input valid, input next_key, input box_invalid, output ready);
endinterface

### sv/morb_stage.sv
// One pipeline stage: scans a slice of bit positions and registers the work item
module morb_stage #(
	parameter int TOP_POS = 63,
	parameter int NBITS   = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  morb_pkg::morb_work_t in_work,
	output logic                out_valid,
	input  logic                out_ready,
	output morb_pkg::morb_work_t out_work
);
	import morb_pkg::*;

	morb_work_t nxt;
	morb_work_t work_s1;
	logic       valid_s1;

	always_comb begin
		nxt = in_work;
		for (int i = 0; i < NBITS; i++) begin
			nxt = morb_step(nxt, 6'(TOP_POS - i));
		end
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_work  = work_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			work_s1 <= nxt;
		end
	end

endmodule

### sv/morton_bigmin_top.sv
// Top level of the Morton BIGMIN block: mode register and the stage chain
//
// Usage: an item on req carries a current key and the min and max keys of a
// query box; the matching item on rsp carries next_key, the smallest key in
// the box above the current key, and box_invalid. Both channels are
// valid/ready; items are taken when valid and ready are high at a clock edge.
// cfg_we/cfg_wdata write the mode bit (0: two dimensions of 32 bits,
// 1: eight dimensions of 8 bits); write it only while no item is in flight.
// Each item taken on req is registered in each of the NSTG stages in turn, and
// rsp.valid is the last stage's valid bit. Each stage scans ceil(KEY_BITS/8)
// bit positions, the last only those left (8 stages of 8 positions at 64 bits).
// Throughput: one item per cycle while rsp is ready; the per-stage bit scan sets
// the cycle time. Reset clears every stage valid bit and the mode bit to two
// dimensions. When rsp stalls, the result holds in the last stage and earlier
// stages keep filling bubbles; req.ready drops only once every stage is full.
module morton_bigmin_top #(
	parameter int KEY_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	morb_req_if.sink    req,
	morb_rsp_if.source  rsp
);
	import morb_pkg::*;

	localparam int STEP_BITS = (KEY_BITS + 7) / 8;
	localparam int NSTG      = (KEY_BITS + STEP_BITS - 1) / STEP_BITS;
	localparam logic [KEY_W-1:0] KMASK =
		(KEY_BITS >= KEY_W) ? '1 : ((64'd1 << KEY_BITS) - 64'd1);

	logic       dims_mode_q;
	logic       vld [NSTG+1];
	logic       rdy [NSTG+1];
	morb_work_t work [NSTG+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_mode_q <= 1'b0;
		end else if (cfg_we) begin
			dims_mode_q <= cfg_wdata;
		end
	end

	always_comb begin
		work[0].cur     = req.current_key & KMASK;
		work[0].zmin    = req.box_min_key & KMASK;
		work[0].zmax    = req.box_max_key & KMASK;
		work[0].best    = '0;
		work[0].invalid = 1'b0;
		work[0].done    = 1'b0;
		work[0].eight   = dims_mode_q;
	end

	assign vld[0]    = req.valid;
	assign req.ready = rdy[0];

	for (genvar g = 0; g < NSTG; g++) begin : g_stg
		localparam int TOP = KEY_BITS - 1 - g * STEP_BITS;
		localparam int NB  = (TOP + 1 < STEP_BITS) ? TOP + 1 : STEP_BITS;
		morb_stage #(
			.TOP_POS (TOP),
			.NBITS   (NB)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[g]),
			.in_ready  (rdy[g]),
			.in_work   (work[g]),
			.out_valid (vld[g+1]),
			.out_ready (rdy[g+1]),
			.out_work  (work[g+1])
		);
	end

	assign rsp.valid       = vld[NSTG];
	assign rdy[NSTG]       = rsp.ready;
	assign rsp.next_key    = work[NSTG].best;
	assign rsp.box_invalid = work[NSTG].invalid;

endmodule

### sv/morb_chk.sv
// Port-level checks for the Morton BIGMIN block and their bind to the top level
module morb_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [63:0]       next_key,
	input logic              box_invalid
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !rsp_valid)
		else $error("result valid during reset");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(next_key)
		&& $stable(box_invalid))
		else $error("stalled result changed");

	a_full_only: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("request refused without a stalled result");

	a_invalid_ones: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && box_invalid |-> next_key == 64'hFFFF_FFFF_FFFF_FFFF)
		else $error("invalid box without all-ones key");

endmodule

bind morton_bigmin_top morb_chk u_morb_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.next_key    (rsp.next_key),
	.box_invalid (rsp.box_invalid)
);
